// ----- src/sls_pkg.sv -----
// Shared types, constants and arithmetic helpers for the structured linear solver.
package sls_pkg;

	localparam int MaxRows = 64;
	localparam int IdxW = $clog2(MaxRows);
	localparam int CntW = IdxW + 1;

	typedef logic signed [31:0] q16_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic         load;
		logic         tail_clr;
		logic         tail_acc;
		logic         t_init;
		logic         w_init;
		logic         mul_start;
		logic         t_sub;
		logic         w_acc;
		logic         div_start;
		logic         div_y;
		logic         x_write;
		logic         sum_clr;
		logic         sum_acc;
		logic         save_s0;
		logic         save_s1;
		logic         y_zero;
		logic         y_one;
		logic         y_from_div;
		logic         den_check;
		logic [IdxW-1:0] addr;
		logic [IdxW-1:0] wr_addr;
	} sls_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic singular;
	} sls_stat_t;

	function automatic q16_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- src/sls_divider.sv -----
// Restoring signed divider for Q16.16 quotients, one quotient bit per cycle.
module sls_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  dividend,
	input  logic signed [63:0]  divisor,
	output logic                done,
	output sls_pkg::q16_t       quotient
);
	import sls_pkg::*;

	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic signed [65:0] sq;

	assign trial = {rem_q[63:0], num_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[63] ? 64'(-dividend) : dividend;
			den_q <= divisor[63] ? 64'(-divisor) : divisor;
			neg_q <= dividend[63] ^ divisor[63];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], num_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign quotient = sat32(sq);

endmodule

// ----- src/sls_datapath.sv -----
// Row memories, multiplier, accumulators and divider of the solver.
module sls_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sls_pkg::sls_cmd_t cmd,
	input  sls_pkg::q16_t     coef_value,
	input  sls_pkg::q16_t     rhs_value,
	input  sls_pkg::q16_t     diag_value,
	input  logic [15:0]       tiny_threshold,
	output sls_pkg::sls_stat_t stat,
	output sls_pkg::q16_t     x_rd
);
	import sls_pkg::*;

	q16_t coef_mem [MaxRows];
	q16_t rhs_mem  [MaxRows];
	q16_t diag_mem [MaxRows];
	q16_t x_mem    [MaxRows];

	q16_t coef_rd, rhs_rd, diag_rd;
	q16_t tail_q, t_q, w_q, y_q, s_q, s0_q, prod_q, div_res;
	logic mul_busy_q;
	logic mul_done_q;
	logic div_done;
	logic singular_q;
	logic signed [63:0] div_num, div_den;
	logic signed [33:0] den_q;
	logic [16:0] tiny;

	assign tiny = (tiny_threshold == 16'd0) ? 17'd1 : {1'b0, tiny_threshold};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coef_mem[cmd.wr_addr] <= coef_value;
			rhs_mem[cmd.wr_addr] <= rhs_value;
			diag_mem[cmd.wr_addr] <= diag_value;
		end
		if (cmd.x_write)
			x_mem[cmd.wr_addr] <= div_res;
		coef_rd <= coef_mem[cmd.addr];
		rhs_rd <= rhs_mem[cmd.addr];
		diag_rd <= diag_mem[cmd.addr];
		x_rd <= x_mem[cmd.addr];
	end

	// Multiplier operands: t_init uses tail*y, t_sub uses w*x.
	logic signed [63:0] full;
	logic signed [65:0] scaled;
	q16_t ma_q, mb_q;
	assign full = ma_q * mb_q;
	assign scaled = 66'(full / 65536);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
		end else begin
			mul_done_q <= mul_busy_q;
			mul_busy_q <= cmd.mul_start;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q <= cmd.t_init ? tail_q : w_q;
			mb_q <= cmd.t_init ? y_q : x_rd;
		end
		if (mul_busy_q)
			prod_q <= sat32(scaled);
		if (cmd.tail_clr)
			tail_q <= '0;
		else if (cmd.tail_acc)
			tail_q <= sat32(66'(tail_q) + 66'(coef_rd));
		if (cmd.w_init)
			w_q <= coef_rd;
		else if (cmd.w_acc)
			w_q <= sat32(66'(w_q) + 66'(coef_rd));
		if (cmd.t_init && !cmd.mul_start)
			t_q <= sat32(66'(rhs_rd) + 66'(prod_q));
		else if (cmd.t_sub)
			t_q <= sat32(66'(t_q) - 66'(prod_q));
		if (cmd.sum_clr)
			s_q <= '0;
		else if (cmd.sum_acc)
			s_q <= sat32(66'(s_q) + 66'(x_rd));
		if (cmd.save_s0)
			s0_q <= s_q;
		if (cmd.save_s1)
			den_q <= 34'(s0_q) + 34'sd65536 - 34'(s_q);
		if (cmd.y_zero)
			y_q <= '0;
		else if (cmd.y_one)
			y_q <= 32'sd65536;
		else if (cmd.y_from_div)
			y_q <= div_res;
	end

	logic signed [33:0] den_mag;
	logic signed [32:0] dmag;
	assign den_mag = den_q[33] ? -den_q : den_q;
	assign dmag = diag_rd[31] ? -33'(diag_rd) : 33'(diag_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			singular_q <= 1'b0;
		else if (cmd.den_check)
			singular_q <= !(den_mag > 34'(tiny));
	end

	assign stat = '{mul_done: mul_done_q, div_done: div_done, singular: singular_q};

	always_comb begin
		if (cmd.div_y) begin
			div_num = 64'(s0_q) <<< 16;
			div_den = 64'(den_q);
		end else begin
			div_num = 64'(t_q) <<< 16;
			div_den = (dmag < 33'(tiny)) ? 64'(tiny) : 64'(diag_rd);
		end
	end

	sls_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_num), .divisor(div_den),
		.done(div_done), .quotient(div_res)
	);

endmodule

// ----- src/sls_ctrl.sv -----
// Sequencer for loading, the two or three substitution passes and result output.
module sls_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    last_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [sls_pkg::IdxW-1:0] out_idx,
	output logic                    out_last,
	output sls_pkg::sls_cmd_t       cmd,
	input  sls_pkg::sls_stat_t      stat
);
	import sls_pkg::*;

	localparam logic [4:0] S_LOAD = 5'd0, S_PSTART = 5'd1, S_TAIL = 5'd2, S_TMUL = 5'd3,
		S_TMW = 5'd4, S_TINIT = 5'd5, S_JRD = 5'd6, S_JMUL = 5'd7, S_JMW = 5'd8,
		S_JSUB = 5'd9, S_JW = 5'd10, S_DRD = 5'd11, S_DDIV = 5'd12, S_DW = 5'd13,
		S_SUM = 5'd14, S_SUMW = 5'd15, S_SUMEND = 5'd16, S_YDIV = 5'd17,
		S_YW = 5'd18, S_ORD = 5'd19, S_OUT = 5'd20, S_DEN = 5'd21, S_SUMRD = 5'd22,
		S_TRD = 5'd23;

	logic [4:0] st_q;
	logic [CntW-1:0] n_q, k_q, j_q;
	logic [1:0] pass_q;
	logic [CntW-1:0] o_q;

	assign in_ready = (st_q == S_LOAD);
	assign out_valid = (st_q == S_OUT);
	assign out_idx = o_q[IdxW-1:0];
	assign out_last = (o_q + 1'b1 == n_q);

	always_comb begin
		cmd = '0;
		cmd.addr = k_q[IdxW-1:0];
		cmd.wr_addr = k_q[IdxW-1:0];
		case (st_q)
			S_LOAD: begin
				cmd.wr_addr = n_q[IdxW-1:0];
				cmd.load = in_valid && (n_q < CntW'(MaxRows));
				cmd.tail_clr = 1'b1;
			end
			S_TAIL: cmd.tail_acc = 1'b1;
			S_TMUL: begin
				cmd.mul_start = 1'b1;
				cmd.t_init = 1'b1;
			end
			S_TINIT: begin
				cmd.t_init = 1'b1;
				cmd.w_init = 1'b1;
			end
			S_JRD: cmd.addr = j_q[IdxW-1:0];
			S_JMUL: begin
				cmd.addr = j_q[IdxW-1:0];
				cmd.mul_start = 1'b1;
			end
			S_JMW: cmd.addr = j_q[IdxW-1:0];
			S_JSUB: begin
				cmd.addr = j_q[IdxW-1:0];
				cmd.t_sub = 1'b1;
			end
			S_JW: begin
				cmd.addr = j_q[IdxW-1:0];
				cmd.w_acc = 1'b1;
			end
			S_DDIV: cmd.div_start = 1'b1;
			S_DW: cmd.x_write = stat.div_done;
			S_PSTART: begin
				cmd.sum_clr = 1'b1;
				cmd.tail_clr = 1'b1;
			end
			S_SUMRD: cmd.addr = j_q[IdxW-1:0];
			S_SUM: begin
				cmd.addr = j_q[IdxW-1:0];
				cmd.sum_acc = 1'b1;
			end
			S_SUMEND: begin
				cmd.save_s0 = (pass_q == 2'd0);
				cmd.save_s1 = (pass_q == 2'd1);
				cmd.y_one = (pass_q == 2'd0);
			end
			S_DEN: cmd.den_check = 1'b1;
			S_YDIV: begin
				cmd.div_y = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_YW: begin
				cmd.div_y = 1'b1;
				cmd.y_from_div = stat.div_done;
			end
			S_ORD, S_OUT: cmd.addr = o_q[IdxW-1:0];
			default: ;
		endcase
		if (st_q == S_LOAD && in_valid && last_row)
			cmd.y_zero = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			n_q <= '0;
			k_q <= '0;
			j_q <= '0;
			o_q <= '0;
			pass_q <= '0;
		end else begin
			case (st_q)
				S_LOAD: if (in_valid) begin
					if (n_q < CntW'(MaxRows))
						n_q <= n_q + 1'b1;
					if (last_row) begin
						pass_q <= '0;
						st_q <= S_PSTART;
					end
				end
				S_PSTART: begin
					k_q <= n_q - 1'b1;
					st_q <= S_TRD;
				end
				S_TRD: st_q <= S_TAIL;
				S_TAIL: st_q <= S_TMUL;
				S_TMUL: st_q <= S_TMW;
				S_TMW: if (stat.mul_done) st_q <= S_TINIT;
				S_TINIT: begin
					j_q <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 < n_q) ? S_JRD : S_DRD;
				end
				S_JRD: st_q <= S_JMUL;
				S_JMUL: st_q <= S_JMW;
				S_JMW: if (stat.mul_done) st_q <= S_JSUB;
				S_JSUB: st_q <= S_JW;
				S_JW: begin
					j_q <= j_q + 1'b1;
					st_q <= (j_q + 1'b1 < n_q) ? S_JRD : S_DRD;
				end
				S_DRD: st_q <= S_DDIV;
				S_DDIV: st_q <= S_DW;
				S_DW: if (stat.div_done) begin
					if (k_q == '0) begin
						j_q <= '0;
						st_q <= (pass_q == 2'd2) ? S_ORD : S_SUMRD;
					end else begin
						k_q <= k_q - 1'b1;
						st_q <= S_TRD;
					end
				end
				S_SUMRD: st_q <= S_SUM;
				S_SUM: begin
					j_q <= j_q + 1'b1;
					st_q <= (j_q + 1'b1 < n_q) ? S_SUMRD : S_SUMEND;
				end
				S_SUMEND: begin
					if (pass_q == 2'd0) begin
						pass_q <= 2'd1;
						st_q <= S_PSTART;
					end else
						st_q <= S_DEN;
				end
				S_DEN: st_q <= S_YDIV;
				S_YDIV: begin
					if (stat.singular) begin
						o_q <= '0;
						st_q <= S_ORD;
					end
				end
				S_YW: if (stat.div_done) begin
					pass_q <= 2'd2;
					st_q <= S_PSTART;
				end
				S_ORD: st_q <= S_OUT;
				S_OUT: if (out_ready) begin
					if (o_q + 1'b1 == n_q) begin
						o_q <= '0;
						n_q <= '0;
						st_q <= S_LOAD;
					end else begin
						o_q <= o_q + 1'b1;
						st_q <= S_ORD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
			if (st_q == S_YDIV && !stat.singular)
				st_q <= S_YW;
			if (st_q == S_DW && stat.div_done && k_q == '0)
				o_q <= '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("output valid while loading");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> in_ready)
		else $error("row stored outside load state");
	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CntW'(MaxRows))
		else $error("row count overflow");

endmodule

// ----- src/structured_linear_solve.sv -----
// Top level of the structured linear solver.
// Rows load one per cycle while in_ready is high; a solve starts on last_row.
// A solve runs two back-substitution passes, and a third unless singular,
// using the shared multiplier and serial divider; each result is held until
// out_ready. Reset (arst_n, asynchronous) empties the row count and sets the
// threshold to 1; row memories are undefined until written.
module structured_linear_solve (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  sls_pkg::q16_t      coef_value,
	input  sls_pkg::q16_t      rhs_value,
	input  sls_pkg::q16_t      diag_value,
	input  logic               last_row,
	output logic               out_valid,
	input  logic               out_ready,
	output sls_pkg::q16_t      solution_value,
	output logic [5:0]         row_index,
	output logic               last_result,
	output logic               singular_flag
);
	import sls_pkg::*;

	logic [15:0] tiny_q;
	sls_cmd_t cmd;
	sls_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tiny_q <= 16'd1;
		else if (cfg_we)
			tiny_q <= cfg_wdata;
	end

	sls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.last_row(last_row), .out_valid(out_valid), .out_ready(out_ready),
		.out_idx(row_index), .out_last(last_result), .cmd(cmd), .stat(stat)
	);

	sls_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .coef_value(coef_value),
		.rhs_value(rhs_value), .diag_value(diag_value), .tiny_threshold(tiny_q),
		.stat(stat), .x_rd(solution_value)
	);

	assign singular_flag = stat.singular;

endmodule

// ----- dv/structured_linear_solve_tb.sv -----
// Self-checking testbench for the structured linear solver: random row batches, scored results.
module structured_linear_solve_tb;
	import sls_pkg::*;

	typedef struct {
		q16_t coef;
		q16_t rhs;
		q16_t diag;
		logic last;
	} row_t;

	typedef struct {
		q16_t       sol;
		logic [5:0] idx;
		logic       last;
		logic       sing;
	} solution_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	q16_t coef_value = 0;
	q16_t rhs_value = 0;
	q16_t diag_value = 0;
	logic last_row = 0;
	logic out_valid;
	logic out_ready = 0;
	q16_t solution_value;
	logic [5:0] row_index;
	logic last_result;
	logic singular_flag;

	row_t pending_rows[$];
	solution_t expected_solutions[$];
	int coef_mem[64], rhs_mem[64], diag_mem[64], sol_mem[64];
	int rows_held = 0;
	int threshold = 1;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int errors = 0, rows_taken = 0, solutions_seen = 0, solves = 0, singular_seen = 0;
	int rows_made = 0;
	int hold_left = 0;
	bit hold_req = 0;

	structured_linear_solve uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .coef_value(coef_value),
		.rhs_value(rhs_value), .diag_value(diag_value), .last_row(last_row),
		.out_valid(out_valid), .out_ready(out_ready), .solution_value(solution_value),
		.row_index(row_index), .last_result(last_result), .singular_flag(singular_flag)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int q_mul(int p, int q);
		return clip32((longint'(p) * longint'(q)) / 65536);
	endfunction

	function automatic int q_div(int t, longint dv);
		return clip32((longint'(t) * 65536) / dv);
	endfunction

	function automatic longint floor_tiny();
		return (threshold == 0) ? 1 : longint'(threshold);
	endfunction

	function automatic void back_substitute(int y, int n);
		int tail, t, w;
		longint d, mag;
		tail = 0;
		for (int k = n - 1; k >= 0; k--) begin
			tail = clip32(longint'(tail) + coef_mem[k]);
			t = clip32(longint'(rhs_mem[k]) + q_mul(tail, y));
			w = coef_mem[k];
			for (int j = k + 1; j < n; j++) begin
				t = clip32(longint'(t) - q_mul(w, sol_mem[j]));
				w = clip32(longint'(w) + coef_mem[j]);
			end
			d = diag_mem[k];
			mag = (d < 0) ? -d : d;
			sol_mem[k] = (mag < floor_tiny()) ? q_div(t, floor_tiny()) : q_div(t, d);
		end
	endfunction

	function automatic int solution_sum(int n);
		int s;
		s = 0;
		for (int k = 0; k < n; k++)
			s = clip32(longint'(s) + sol_mem[k]);
		return s;
	endfunction

	function automatic void absorb_row(row_t r);
		int n, s0, s1;
		longint den, mag;
		bit sing;
		solution_t e;
		if (rows_held < 64) begin
			coef_mem[rows_held] = r.coef;
			rhs_mem[rows_held] = r.rhs;
			diag_mem[rows_held] = r.diag;
			rows_held++;
		end
		if (!r.last)
			return;
		n = rows_held;
		rows_held = 0;
		back_substitute(0, n);
		s0 = solution_sum(n);
		back_substitute(65536, n);
		s1 = solution_sum(n);
		den = longint'(s0) + 65536 - longint'(s1);
		mag = (den < 0) ? -den : den;
		sing = !(mag > floor_tiny());
		if (!sing)
			back_substitute(clip32((longint'(s0) * 65536) / den), n);
		solves++;
		for (int k = 0; k < n; k++) begin
			e.sol = sol_mem[k];
			e.idx = k[5:0];
			e.last = (k == n - 1);
			e.sing = sing;
			expected_solutions.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		row_t r;
		row_t taken;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				taken.coef = coef_value;
				taken.rhs = rhs_value;
				taken.diag = diag_value;
				taken.last = last_row;
				absorb_row(taken);
				rows_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					r = pending_rows.pop_front();
					coef_value <= r.coef;
					rhs_value <= r.rhs;
					diag_value <= r.diag;
					last_row <= r.last;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// The long hold starts once results are waiting, so the output backs up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && out_valid) begin
			hold_left <= 4000;
			hold_req <= 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 0;
		else if (hold_left > 1 || hold_req)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : score
		solution_t e;
		if (arst_n && out_valid && out_ready) begin
			solutions_seen++;
			if (expected_solutions.size() == 0) begin
				$error("unexpected solution transfer: row_index %0d value %0d",
					row_index, solution_value);
				errors++;
			end else begin
				e = expected_solutions.pop_front();
				if (solution_value !== e.sol) begin
					$error("solution_value: expected %0d, got %0d", e.sol, solution_value);
					errors++;
				end
				if (row_index !== e.idx) begin
					$error("row_index: expected %0d, got %0d", e.idx, row_index);
					errors++;
				end
				if (last_result !== e.last) begin
					$error("last_result: expected %0b, got %0b", e.last, last_result);
					errors++;
				end
				if (singular_flag !== e.sing) begin
					$error("singular_flag: expected %0b, got %0b", e.sing, singular_flag);
					errors++;
				end
				if (e.sing && e.last)
					singular_seen++;
			end
		end
	end

	function automatic q16_t random_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3, 4: return $urandom;
			5: return $urandom_range(0, 65535) - 32768;
			default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
		endcase
	endfunction

	function automatic q16_t random_diag();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return $urandom_range(0, 131070) - 65535;
			2: return $urandom;
			default: return ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(65536, 16 * 65536);
		endcase
	endfunction

	function automatic void queue_row(q16_t a, q16_t b, q16_t d, logic last);
		row_t r;
		r.coef = a;
		r.rhs = b;
		r.diag = d;
		r.last = last;
		pending_rows.push_back(r);
		rows_made++;
	endfunction

	function automatic void queue_batch(int n);
		for (int k = 0; k < n; k++)
			queue_row(random_value(), random_value(), random_diag(), k == n - 1);
	endfunction

	task automatic wait_idle();
		while (pending_rows.size() > 0 || in_valid || expected_solutions.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_threshold(int v);
		@(posedge clk);
		cfg_wdata <= v[15:0];
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		threshold = v;
	endtask

	task automatic random_phase(int quota);
		int target;
		target = rows_made + quota;
		while (rows_made < target) begin
			if ($urandom_range(0, 9) == 0)
				queue_batch($urandom_range(9, 24));
			else
				queue_batch($urandom_range(1, 8));
			if ($urandom_range(0, 4) == 0)
				queue_row(random_value(), random_value(), random_diag(), 0);
			if ($urandom_range(0, 12) == 0)
				wait_idle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n = 1;
		repeat (2) @(posedge clk);

		// Directed rows at the reset threshold.
		queue_row(32'sh10000, 32'sh10000, 32'sh10000, 1);
		queue_row(0, 32'sh7fffffff, 0, 1);
		queue_row(32'sh80000000, 32'sh80000000, 32'shffffffff, 0);
		queue_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
		queue_row(32'sh8000, 32'sh20000, -32'sh30000, 0);
		queue_row(-32'sh4000, 32'sh10000, 32'sh20000, 0);
		queue_row(32'sh1000, -32'sh50000, 32'sh80000000, 1);
		queue_row(32'sh7fffffff, 32'sh80000000, 1, 0);
		queue_row(32'sh7fffffff, 32'sh7fffffff, -1, 1);
		queue_row(0, 0, 0, 1);
		queue_row($urandom, $urandom, $urandom, 1);
		wait_idle();

		set_threshold(65535);
		queue_row(32'sh10000, 32'sh10000, 32'shffff, 0);
		queue_row(32'sh10000, 32'sh10000, -32'shffff, 0);
		queue_row(32'sh10000, 32'sh10000, 32'sh10000, 1);
		queue_batch(66);
		wait_idle();

		set_threshold(0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(85);
		wait_idle();

		set_threshold($urandom_range(1, 65535));
		send_idle_pct = 61;
		recv_stall_pct = 0;
		random_phase(85);
		wait_idle();

		set_threshold(1);
		send_idle_pct = 0;
		recv_stall_pct = 61;
		hold_req = 1;
		queue_batch(66);
		random_phase(85);
		wait_idle();

		set_threshold($urandom_range(1, 65535));
		send_idle_pct = 26;
		recv_stall_pct = 26;
		random_phase(85);
		wait_idle();
		repeat (300) @(posedge clk);

		$display("Covered %0d rows in %0d solves, %0d solutions scored, %0d singular solves.",
			rows_taken, solves, solutions_seen, singular_seen);
		$display("Thresholds at 0, 1, 65535 and random; full-store drop and long output hold.");
		if (errors == 0 && expected_solutions.size() == 0)
			$display("structured_linear_solve_tb: done, clean");
		else
			$display("structured_linear_solve_tb: done, errors");
		$finish;
	end

	initial begin
		#40000000;
		$display("structured_linear_solve_tb: done, errors");
		$finish;
	end

endmodule
